// ===== hw/rtl/x86_64_instruction_length_decoder_defines.svh =====
// Assertion macros shared by the checker.
`ifndef X86_64_INSTRUCTION_LENGTH_DECODER_DEFINES_SVH
`define X86_64_INSTRUCTION_LENGTH_DECODER_DEFINES_SVH

`define ILD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ild check failed");

`define ILD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ild check failed");

`endif

// ===== hw/rtl/ild_pkg.sv =====
`timescale 1ns / 1ps
package ild_pkg;
    localparam int unsigned WindowBytes = 15;
    localparam int unsigned PosW = 5;

    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_PUSH  = 2'd1;
    localparam logic [1:0] CLS_RET   = 2'd2;
    localparam logic [1:0] CLS_MOV   = 2'd3;

    localparam logic [7:0] OP_OSZ  = 8'h66;
    localparam logic [7:0] OP_ASZ  = 8'h67;
    localparam logic [7:0] OP_ESC  = 8'h0F;
    localparam logic [7:0] OP_E38  = 8'h38;
    localparam logic [7:0] OP_E3A  = 8'h3A;
    localparam logic [7:0] OP_VEX3 = 8'hC4;
    localparam logic [7:0] OP_VEX2 = 8'hC5;
    localparam logic [7:0] OP_EVEX = 8'h62;
    localparam logic [7:0] OP_LOCK = 8'hF0;
    localparam logic [7:0] OP_REX  = 8'h40;
    localparam logic [7:0] OP_F6   = 8'hF6;
    localparam logic [7:0] OP_FF   = 8'hFF;

    localparam logic [255:0] MRM_ONE = {
        8'hC0, 8'hC0, 8'h00, 8'h00, 8'hFF, 8'h0F, 8'h00, 8'hC3,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
        8'h00, 8'h00, 8'h0A, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F};
    localparam logic [255:0] MRM_ESC = {
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF,
        8'hFF, 8'hFF, 8'hF8, 8'h38, 8'hFF, 8'hFF, 8'h00, 8'h00,
        8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hA0, 8'h0F};

    // per-byte prefix classification from one lane
    typedef struct packed {
        logic is_pfx;
        logic is_osz;
        logic is_asz;
        logic is_rex;
        logic rex_w;
    } t_lane_info;

    typedef struct packed {
        logic [PosW-1:0] len;
        logic [1:0]      cls;
        logic            rip;
        logic [63:0]     tgt;
    } t_result;

    function automatic logic [3:0] imm_plain(logic [7:0] op, logic o16, logic w, logic a32);
        logic [3:0] r;
        r = 4'd0;
        if (op < 8'h40 && op[2:0] == 3'd4) r = 4'd1;
        else if (op < 8'h40 && op[2:0] == 3'd5) r = o16 ? 4'd2 : 4'd4;
        else if (op inside {[8'h70:8'h7F], [8'hB0:8'hB7], [8'hE0:8'hE7]}) r = 4'd1;
        else if (op inside {[8'hB8:8'hBF]}) r = w ? 4'd8 : (o16 ? 4'd2 : 4'd4);
        else if (op inside {[8'hA0:8'hA3]}) r = a32 ? 4'd4 : 4'd8;
        else if (op inside {8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hC0, 8'hC1,
                            8'hC6, 8'hCD, 8'hD4, 8'hD5, 8'hEB}) r = 4'd1;
        else if (op inside {8'hC2, 8'hCA}) r = 4'd2;
        else if (op == 8'hC8) r = 4'd3;
        else if (op inside {8'hE8, 8'hE9}) r = 4'd4;
        else if (op inside {8'h68, 8'h69, 8'h81, 8'hA9, 8'hC7}) r = o16 ? 4'd2 : 4'd4;
        return r;
    endfunction

    function automatic logic [3:0] imm_escaped(logic [7:0] op);
        logic [3:0] r;
        r = 4'd0;
        if (op inside {8'h70, 8'h71, 8'h72, 8'h73, 8'hA4, 8'hAC, 8'hBA,
                       8'hC2, 8'hC4, 8'hC5, 8'hC6, 8'h0F}) r = 4'd1;
        else if (op inside {[8'h80:8'h8F]}) r = 4'd4;
        return r;
    endfunction
endpackage

// ===== hw/rtl/ild_if.sv =====
`timescale 1ns / 1ps
interface ild_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] inst_address;
    logic [63:0] window_low;
    logic [55:0] window_high;
    logic [3:0]  avail_bytes;
    modport source (output valid, inst_address, window_low, window_high, avail_bytes,
                    input ready);
    modport sink (input valid, inst_address, window_low, window_high, avail_bytes,
                  output ready);
endinterface

interface ild_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  inst_length;
    logic [1:0]  mnemonic_class;
    logic        rip_relative;
    logic [63:0] rip_target;
    modport source (output valid, inst_length, mnemonic_class, rip_relative, rip_target,
                    input ready);
    modport sink (input valid, inst_length, mnemonic_class, rip_relative, rip_target,
                  output ready);
endinterface

// ===== hw/rtl/ild_lane.sv =====
`timescale 1ns / 1ps
module ild_lane (
    input  logic [7:0]           i_byte,
    output ild_pkg::t_lane_info  o_info
);
    always_comb begin
        o_info.is_osz = (i_byte == ild_pkg::OP_OSZ);
        o_info.is_asz = (i_byte == ild_pkg::OP_ASZ);
        o_info.is_rex = (i_byte[7:4] == ild_pkg::OP_REX[7:4]);
        o_info.rex_w  = i_byte[3];
        o_info.is_pfx = o_info.is_osz || o_info.is_asz || o_info.is_rex ||
                        (i_byte inside {ild_pkg::OP_LOCK, 8'hF2, 8'hF3, 8'h2E, 8'h3E,
                                        8'h26, 8'h64, 8'h65, 8'h36});
    end
endmodule

// ===== hw/rtl/ild_merge.sv =====
`timescale 1ns / 1ps
module ild_merge (
    input  logic [119:0]                 i_win,
    input  logic [3:0]                   i_end,
    input  logic [63:0]                  i_ip,
    input  ild_pkg::t_lane_info [14:0]   i_info,
    output ild_pkg::t_result             o_res,
    output logic [63:0]                  o_base,
    output logic [31:0]                  o_disp
);
    logic [7:0] w [0:31];
    logic [4:0] p, e, pos, hdr, mp, vi_pos;
    logic       o16, a32, rexw, stop, fail, esc, e38, e3a, need, vi, vex;
    logic [7:0] op, vop, mrm;
    logic [4:0] map;
    logic [3:0] imm;
    logic [1:0] cls;
    logic       rip;

    // walk the ModRM at mp; returns new pos, sets rip flag
    function automatic logic [5:0] walk(logic [4:0] at, logic [4:0] en, logic [7:0] m,
                                        logic [2:0] base, logic asz, output logic r);
        logic [5:0] q;
        q = {1'b0, at} + 6'd1;
        r = 1'b0;
        if (m[7:6] != 2'd3) begin
            if (m[2:0] == 3'd4) begin
                if (q < {1'b0, en}) begin
                    q = q + 6'd1;
                    if (m[7:6] == 2'd0 && base == 3'd5) q = q + 6'd4;
                    else if (m[7:6] == 2'd1) q = q + 6'd1;
                    else if (m[7:6] == 2'd2) q = q + 6'd4;
                end
            end else if (m[7:6] == 2'd0 && m[2:0] == 3'd5) begin
                if (q + 6'd4 <= {1'b0, en}) begin
                    q = q + 6'd4;
                    r = !asz;
                end
            end else if (m[7:6] == 2'd1) q = q + 6'd1;
            else if (m[7:6] == 2'd2) q = q + 6'd4;
        end
        return q;
    endfunction

    logic [5:0] wq;
    logic       wr;
    logic [5:0] fin;

    always_comb begin
        for (int k = 0; k < 32; k++)
            w[k] = (k < int'(ild_pkg::WindowBytes)) ? i_win[k*8 +: 8] : 8'h00;
        e = {1'b0, i_end};
        p = 5'd0; o16 = 1'b0; a32 = 1'b0; rexw = 1'b0; stop = 1'b0;
        for (int k = 0; k < int'(ild_pkg::WindowBytes); k++) begin
            if (!stop && k < e && i_info[k].is_pfx) begin
                p = 5'(k + 1);
                if (i_info[k].is_osz) o16 = 1'b1;
                if (i_info[k].is_asz) a32 = 1'b1;
                rexw = i_info[k].is_rex ? i_info[k].rex_w : 1'b0;
            end else stop = 1'b1;
        end
        fail = (p >= e);
        op = w[p]; pos = p + 5'd1;
        esc = 1'b0; e38 = 1'b0; e3a = 1'b0; vex = 1'b0; vi = 1'b0; vop = 8'h00;
        map = 5'd1; hdr = 5'd0; need = 1'b0; imm = 4'd0; cls = ild_pkg::CLS_OTHER;
        mp = 5'd0; vi_pos = 5'd0;
        if (!fail && (op == ild_pkg::OP_VEX3 || op == ild_pkg::OP_VEX2 ||
                      op == ild_pkg::OP_EVEX)) begin
            vex = 1'b1;
            hdr = (op == ild_pkg::OP_VEX2) ? 5'd1 : (op == ild_pkg::OP_VEX3) ? 5'd2 : 5'd3;
            if ({1'b0, pos} + {1'b0, hdr} >= {1'b0, e}) fail = 1'b1;
            if (op == ild_pkg::OP_VEX3) map = {w[pos][4:0]};
            else if (op == ild_pkg::OP_EVEX) map = {3'd0, w[pos][1:0]};
            pos = pos + hdr;
            vop = w[pos];
            pos = pos + 5'd1;
            if (map == 5'd3) vi = 1'b1;
            else if (map == 5'd1 && ((vop inside {[8'h70:8'h73]}) ||
                     (vop inside {8'hC2, 8'hC4, 8'hC5, 8'hC6}))) vi = 1'b1;
            imm = {3'd0, vi};
            need = !(map == 5'd1 && vop == 8'h77);
            if (need && pos >= e) fail = 1'b1;
        end else if (!fail) begin
            if (op == ild_pkg::OP_ESC) begin
                esc = 1'b1;
                if (pos >= e) fail = 1'b1;
                op = w[pos]; pos = pos + 5'd1;
                if (op == ild_pkg::OP_E38 || op == ild_pkg::OP_E3A) begin
                    e38 = (op == ild_pkg::OP_E38); e3a = !e38;
                    if (pos >= e) fail = 1'b1;
                    op = w[pos]; pos = pos + 5'd1;
                end
            end
            if (!esc) begin
                if (op inside {[8'h50:8'h57], 8'h68, 8'h6A}) cls = ild_pkg::CLS_PUSH;
                else if (op inside {8'hC3, 8'hCB, 8'hC2, 8'hCA}) cls = ild_pkg::CLS_RET;
                else if (op inside {[8'h88:8'h8C], 8'h8E, [8'hA0:8'hA3], [8'hB0:8'hBF],
                                    8'hC6, 8'hC7}) cls = ild_pkg::CLS_MOV;
            end else if (!e38 && !e3a) begin
                if (op inside {8'hB6, 8'hB7, 8'hBE, 8'hBF}) cls = ild_pkg::CLS_MOV;
            end
            if (e3a) imm = 4'd1;
            else if (e38) imm = 4'd0;
            else if (esc) imm = ild_pkg::imm_escaped(op);
            else imm = ild_pkg::imm_plain(op, o16, rexw, a32);
            need = (e38 || e3a) ? 1'b1 : esc ? ild_pkg::MRM_ESC[op] : ild_pkg::MRM_ONE[op];
            if (need) begin
                if (pos >= e) fail = 1'b1;
                if (!esc && op == ild_pkg::OP_FF && w[pos][5:3] == 3'd6)
                    cls = ild_pkg::CLS_PUSH;
                if (!esc && (op == ild_pkg::OP_F6 || op == 8'hF7) && w[pos][5:3] <= 3'd1)
                    imm = (op == ild_pkg::OP_F6) ? 4'd1 : (o16 ? 4'd2 : 4'd4);
            end
        end
        mp = pos;
        mrm = w[mp];
        wq = {1'b0, mp};
        wr = 1'b0;
        if (need) wq = walk(mp, e, mrm, w[5'(mp + 5'd1)][2:0], a32, wr);
        fin = wq + {2'd0, imm};
        if (!vex && fin > {1'b0, e}) fin = {1'b0, e};
        rip = wr && !fail;
        vi_pos = 5'(wq);
        o_disp = {w[5'(mp + 5'd4)], w[5'(mp + 5'd3)], w[5'(mp + 5'd2)], w[5'(mp + 5'd1)]};
        o_base = i_ip + {59'd0, vi_pos} + {60'd0, imm};
        o_res.len = fail ? 5'd0 : fin[4:0];
        o_res.cls = fail ? ild_pkg::CLS_OTHER : cls;
        o_res.rip = rip;
        o_res.tgt = 64'd0;
    end
endmodule

// ===== hw/rtl/x86_64_instruction_length_decoder.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake      payload
// s_in     in   valid/ready    inst_address, window_low, window_high, avail_bytes
// m_out    out  valid/ready    inst_length, mnemonic_class, rip_relative, rip_target
// Lanes and merge feed the first stage, the RIP target add feeds the second.
// One transaction per cycle while the output is taken; a stalled output holds both stages.
// Synchronous active-low reset empties both stages.
module x86_64_instruction_length_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ild_in_if.sink      s_in,
    ild_out_if.source   m_out
);
    logic [119:0]                   win;
    ild_pkg::t_lane_info [14:0]     info;
    ild_pkg::t_result               res;
    logic [63:0]                    base;
    logic [31:0]                    disp;
    logic                           r_v1, r_v2;
    ild_pkg::t_result               r_res1, r_res2;
    logic [63:0]                    r_base, r_disp;
    logic                           adv2, adv1;

    assign win = {s_in.window_high, s_in.window_low};

    for (genvar g = 0; g < 15; g++) begin : g_lane
        ild_lane u_lane (.i_byte(win[g*8 +: 8]), .o_info(info[g]));
    end

    ild_merge u_merge (
        .i_win(win), .i_end(s_in.avail_bytes), .i_ip(s_in.inst_address),
        .i_info(info), .o_res(res), .o_base(base), .o_disp(disp)
    );

    assign adv2 = !r_v2 || m_out.ready;
    assign adv1 = !r_v1 || adv2;
    assign s_in.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= s_in.valid;
            if (adv2) r_v2 <= r_v1;
        end
        if (adv1) begin
            r_res1 <= res;
            r_base <= base;
            r_disp <= {{32{disp[31]}}, disp};
        end
        if (adv2) begin
            r_res2 <= '{len: r_res1.len, cls: r_res1.cls, rip: r_res1.rip,
                        tgt: r_res1.rip ? (r_base + r_disp) : 64'd0};
        end
    end

    assign m_out.valid          = r_v2;
    assign m_out.inst_length    = r_res2.len;
    assign m_out.mnemonic_class = r_res2.cls;
    assign m_out.rip_relative   = r_res2.rip;
    assign m_out.rip_target     = r_res2.tgt;
endmodule

// ===== hw/rtl/ild_checker.sv =====
`timescale 1ns / 1ps
`include "x86_64_instruction_length_decoder_defines.svh"
module ild_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  out_len,
    input logic [1:0]  out_cls,
    input logic        out_rip,
    input logic [63:0] out_tgt
);
    `ILD_ASSERT_IMP(a_err_clean, i_clk, i_rst_n, out_valid && out_len == 5'd0, out_cls == 2'd0 && !out_rip)
    `ILD_ASSERT_IMP(a_tgt_zero, i_clk, i_rst_n, out_valid && !out_rip, out_tgt == 64'd0)
    `ILD_ASSERT_IMP(a_len_max, i_clk, i_rst_n, out_valid, out_len <= 5'd21)
    `ILD_ASSERT_IMP(a_idle_ready, i_clk, i_rst_n, !out_valid, in_ready)
    `ILD_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_len))
endmodule

bind x86_64_instruction_length_decoder ild_checker u_ild_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready),
    .out_len(m_out.inst_length), .out_cls(m_out.mnemonic_class),
    .out_rip(m_out.rip_relative), .out_tgt(m_out.rip_target)
);
